>>> hw/rtl/lstp_pkg.sv
// ----------------------------------------------------------------------------
// Lidar scan to points: shared package
// Constants, register codes and the arctangent table of the rotator.
// ----------------------------------------------------------------------------
package lstp_pkg;

   localparam int MAX_BEAMS     = 1440;
   localparam int CORDIC_STAGES = 28;
   localparam int IDX_W         = 11;
   localparam int XW            = 44;   // rotator datapath, Q20.24 signed
   localparam int ZW            = 34;   // rotator angle, Q6.28 signed

   localparam logic [29:0] CORDIC_GAIN = 30'd652032875;
   localparam logic signed [ZW-1:0] Q28_PI      = 34'sd843314857;
   localparam logic signed [ZW-1:0] Q28_HALF_PI = 34'sd421657428;
   localparam logic signed [ZW-1:0] Q28_TWO_PI  = 34'sd1686629713;

   localparam logic signed [ZW-1:0] ATAN_TABLE [0:CORDIC_STAGES-1] = '{
      34'sd210828714, 34'sd124459457, 34'sd65760959, 34'sd33381290,
      34'sd16755422,  34'sd8385879,   34'sd4193963,  34'sd2097109,
      34'sd1048571,   34'sd524287,    34'sd262144,   34'sd131072,
      34'sd65536,     34'sd32768,     34'sd16384,    34'sd8192,
      34'sd4096,      34'sd2048,      34'sd1024,     34'sd512,
      34'sd256,       34'sd128,       34'sd64,       34'sd32,
      34'sd16,        34'sd8,         34'sd4,        34'sd2
   };

   typedef enum logic [3:0] {
      REG_ANGLE_START = 4'd0,
      REG_ANGLE_STEP  = 4'd1,
      REG_RANGE_LOW   = 4'd2,
      REG_RANGE_HIGH  = 4'd3,
      REG_RANGE_SCALE = 4'd4,
      REG_ROT_ROW0    = 4'd5,
      REG_ROT_ROW1    = 4'd6,
      REG_TRANSLATION = 4'd7
   } csr_index_type;

endpackage

>>> hw/rtl/lidar_scan_to_points_core.sv
// Pipeline: a sample passes through 35 register stages from the req transfer to rsp_tvalid
// (3 front stages, 28 rotator stages, 4 transform stages).
// Throughput: one sample per cycle; the whole pipeline advances together and
// holds while the result register is full and rsp_tready is low.
// Reset clears all valid bits and loads the register defaults (identity
// rotation, open range window, unit gain).
// ----------------------------------------------------------------------------
// Lidar scan to points core
// Range filter, beam angle, pipelined CORDIC polar to Cartesian, 2x2 transform.
// ----------------------------------------------------------------------------
module lidar_scan_to_points_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // range_sample[31:0], beam_index[42:32], zero fill
   input  logic        req_tlast,   // scan_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // point_x[31:0], point_y[63:32], beam_angle[95:64]
   output logic        rsp_tuser,   // point_kept
   output logic        rsp_tlast,   // scan_last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int N = lstp_pkg::CORDIC_STAGES;
   localparam int XW = lstp_pkg::XW;
   localparam int ZW = lstp_pkg::ZW;

   // configuration
   logic [31:0] angle_start_ff, angle_step_ff, range_low_ff, range_high_ff;
   logic [31:0] range_scale_ff;
   logic [63:0] rot_row0_ff, rot_row1_ff, translation_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_start_ff <= '0;
         angle_step_ff  <= '0;
         range_low_ff   <= '0;
         range_high_ff  <= '1;
         range_scale_ff <= 32'h4000_0000;
         rot_row0_ff    <= 64'h0000_0000_4000_0000;
         rot_row1_ff    <= 64'h4000_0000_0000_0000;
         translation_ff <= '0;
      end else if (csr_valid) begin
         case (lstp_pkg::csr_index_type'(csr_index))
            lstp_pkg::REG_ANGLE_START: angle_start_ff <= csr_data[31:0];
            lstp_pkg::REG_ANGLE_STEP:  angle_step_ff  <= csr_data[31:0];
            lstp_pkg::REG_RANGE_LOW:   range_low_ff   <= csr_data[31:0];
            lstp_pkg::REG_RANGE_HIGH:  range_high_ff  <= csr_data[31:0];
            lstp_pkg::REG_RANGE_SCALE: range_scale_ff <= csr_data[31:0];
            lstp_pkg::REG_ROT_ROW0:    rot_row0_ff    <= csr_data;
            lstp_pkg::REG_ROT_ROW1:    rot_row1_ff    <= csr_data;
            lstp_pkg::REG_TRANSLATION: translation_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // global advance: the result register is empty or being drained
   logic adv;
   logic out_v_ff;
   assign adv        = !out_v_ff || rsp_tready;
   assign req_tready = adv;

   // stage 1: filter, angle product, range product
   logic [31:0]       r_in;
   logic [10:0]       idx_in;
   logic              kept_in;
   logic              v1_ff, kept1_ff, last1_ff;
   logic signed [43:0] aprod1_ff;
   logic [63:0]       rprod1_ff;

   assign r_in   = req_tdata[31:0];
   assign idx_in = req_tdata[42:32];
   assign kept_in = !(r_in <= range_low_ff || r_in >= range_high_ff || r_in == '1 ||
                      r_in == '0 || idx_in >= 11'(lstp_pkg::MAX_BEAMS));

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_tvalid;
      if (adv) begin
         kept1_ff  <= kept_in;
         last1_ff  <= req_tlast;
         aprod1_ff <= $signed(angle_step_ff) * $signed({1'b0, idx_in});
         rprod1_ff <= 64'(r_in) * 64'(range_scale_ff);
      end
   end

   // stage 2: wrap angle, saturate scaled range
   logic              v2_ff, kept2_ff, last2_ff;
   logic [31:0]       ang2_ff, s2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
      if (adv) begin
         kept2_ff <= kept1_ff;
         last2_ff <= last1_ff;
         ang2_ff  <= angle_start_ff + aprod1_ff[31:0];
         s2_ff    <= (rprod1_ff[63:62] != 2'b00) ? '1 : rprod1_ff[61:30];
      end
   end

   // stage 3: reduce angle to the right half plane, apply gain
   logic signed [ZW-1:0] za, zb, zc;
   logic                 flip_in;
   logic [61:0]          xm;

   always_comb begin
      za = ZW'($signed(ang2_ff));
      if (za > lstp_pkg::Q28_PI) zb = za - lstp_pkg::Q28_TWO_PI;
      else if (za < -lstp_pkg::Q28_PI) zb = za + lstp_pkg::Q28_TWO_PI;
      else zb = za;
      flip_in = 1'b1;
      if (zb > lstp_pkg::Q28_HALF_PI) zc = zb - lstp_pkg::Q28_PI;
      else if (zb < -lstp_pkg::Q28_HALF_PI) zc = zb + lstp_pkg::Q28_PI;
      else begin
         zc = zb;
         flip_in = 1'b0;
      end
      xm = 62'(s2_ff) * 62'(lstp_pkg::CORDIC_GAIN);
   end

   // rotator stages, index 0 is the stage 3 register
   logic                 cv_ff    [0:N];
   logic                 ckept_ff [0:N];
   logic                 clast_ff [0:N];
   logic                 cflip_ff [0:N];
   logic [31:0]          cang_ff  [0:N];
   logic signed [XW-1:0] cx_ff    [0:N];
   logic signed [XW-1:0] cy_ff    [0:N];
   logic signed [ZW-1:0] cz_ff    [0:N];

   always_ff @(posedge clock) begin
      if (reset) cv_ff[0] <= 1'b0;
      else if (adv) cv_ff[0] <= v2_ff;
      if (adv) begin
         ckept_ff[0] <= kept2_ff;
         clast_ff[0] <= last2_ff;
         cflip_ff[0] <= flip_in;
         cang_ff[0]  <= ang2_ff;
         cx_ff[0]    <= $signed({4'b0000, xm[61:22]});
         cy_ff[0]    <= '0;
         cz_ff[0]    <= zc;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_cordic
      logic signed [XW-1:0] dx, dy;
      assign dx = cy_ff[i] >>> i;
      assign dy = cx_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (reset) cv_ff[i+1] <= 1'b0;
         else if (adv) cv_ff[i+1] <= cv_ff[i];
         if (adv) begin
            ckept_ff[i+1] <= ckept_ff[i];
            clast_ff[i+1] <= clast_ff[i];
            cflip_ff[i+1] <= cflip_ff[i];
            cang_ff[i+1]  <= cang_ff[i];
            if (cz_ff[i] >= 0) begin
               cx_ff[i+1] <= cx_ff[i] - dx;
               cy_ff[i+1] <= cy_ff[i] + dy;
               cz_ff[i+1] <= cz_ff[i] - lstp_pkg::ATAN_TABLE[i];
            end else begin
               cx_ff[i+1] <= cx_ff[i] + dx;
               cy_ff[i+1] <= cy_ff[i] - dy;
               cz_ff[i+1] <= cz_ff[i] + lstp_pkg::ATAN_TABLE[i];
            end
         end
      end
   end

   // stage 4: flip, round to Q16.16, saturate
   localparam logic signed [XW-1:0] PMAX = XW'(64'sd2147483647);
   logic signed [XW-1:0] xf, yf, xr, yr;
   logic signed [31:0]   px_in, py_in;

   always_comb begin
      xf = cflip_ff[N] ? -cx_ff[N] : cx_ff[N];
      yf = cflip_ff[N] ? -cy_ff[N] : cy_ff[N];
      xr = (xf + XW'(128)) >>> 8;
      yr = (yf + XW'(128)) >>> 8;
      px_in = (xr > PMAX) ? 32'sd2147483647 : (xr < -PMAX) ? -32'sd2147483647 : xr[31:0];
      py_in = (yr > PMAX) ? 32'sd2147483647 : (yr < -PMAX) ? -32'sd2147483647 : yr[31:0];
   end

   logic              v4_ff, kept4_ff, last4_ff;
   logic [31:0]       ang4_ff;
   logic signed [31:0] px4_ff, py4_ff;

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= cv_ff[N];
      if (adv) begin
         kept4_ff <= ckept_ff[N];
         last4_ff <= clast_ff[N];
         ang4_ff  <= cang_ff[N];
         px4_ff   <= px_in;
         py4_ff   <= py_in;
      end
   end

   // stage 5: matrix products
   logic              v5_ff, kept5_ff, last5_ff;
   logic [31:0]       ang5_ff;
   logic signed [63:0] p00_ff, p01_ff, p10_ff, p11_ff;

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (adv) v5_ff <= v4_ff;
      if (adv) begin
         kept5_ff <= kept4_ff;
         last5_ff <= last4_ff;
         ang5_ff  <= ang4_ff;
         p00_ff   <= $signed(rot_row0_ff[31:0])  * px4_ff;
         p01_ff   <= $signed(rot_row0_ff[63:32]) * py4_ff;
         p10_ff   <= $signed(rot_row1_ff[31:0])  * px4_ff;
         p11_ff   <= $signed(rot_row1_ff[63:32]) * py4_ff;
      end
   end

   // stage 6: row sums with rounding offset
   logic              v6_ff, kept6_ff, last6_ff;
   logic [31:0]       ang6_ff;
   logic signed [64:0] sx6_ff, sy6_ff;

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else if (adv) v6_ff <= v5_ff;
      if (adv) begin
         kept6_ff <= kept5_ff;
         last6_ff <= last5_ff;
         ang6_ff  <= ang5_ff;
         sx6_ff   <= 65'(p00_ff) + 65'(p01_ff) + 65'sd536870912;
         sy6_ff   <= 65'(p10_ff) + 65'(p11_ff) + 65'sd536870912;
      end
   end

   // stage 7: scale down, translate, saturate, hold for the consumer
   localparam logic signed [64:0] OMAX = 65'sd2147483647;
   localparam logic signed [64:0] OMIN = -65'sd2147483648;
   logic signed [64:0] tx, ty;
   logic signed [31:0] ox_in, oy_in;

   always_comb begin
      tx = (sx6_ff >>> 30) + 65'($signed(translation_ff[31:0]));
      ty = (sy6_ff >>> 30) + 65'($signed(translation_ff[63:32]));
      ox_in = (tx > OMAX) ? 32'h7FFF_FFFF : (tx < OMIN) ? 32'h8000_0000 : tx[31:0];
      oy_in = (ty > OMAX) ? 32'h7FFF_FFFF : (ty < OMIN) ? 32'h8000_0000 : ty[31:0];
   end

   logic        kept_out_ff, last_out_ff;
   logic [31:0] ox_ff, oy_ff, ang_out_ff;

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (adv) out_v_ff <= v6_ff;
      if (adv) begin
         kept_out_ff <= kept6_ff;
         last_out_ff <= last6_ff;
         ang_out_ff  <= ang6_ff;
         ox_ff       <= kept6_ff ? ox_in : '0;
         oy_ff       <= kept6_ff ? oy_in : '0;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {ang_out_ff, oy_ff, ox_ff};
   assign rsp_tuser  = kept_out_ff;
   assign rsp_tlast  = last_out_ff;

endmodule

>>> hw/rtl/lstp_checker.sv
// ----------------------------------------------------------------------------
// Lidar scan to points: port checker
// Watches the core's ports and flags handshake and output slips.
// ----------------------------------------------------------------------------
module lstp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic        rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[63:0] == 64'd0)
      else $error("rejected sample carries a point");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output backpressure");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind lidar_scan_to_points_core lstp_checker u_lstp_checker (.*);

>>> dv/lstp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lidar scan to points: result checker
// Mirrors the register writes, predicts the point for each sample transfer
// and compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module lstp_scoreboard (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [95:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [63:0] csr_data,
   output int          error_count,
   output int          pending_points
);

   typedef struct packed {
      logic        kept;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] angle;
      logic        last;
   } point_type;

   localparam longint PI_Q28      = 843314857;
   localparam longint HALF_PI_Q28 = 421657428;
   localparam longint TWO_PI_Q28  = 1686629713;
   localparam longint GAIN_Q30    = 652032875;

   longint atan_q28 [28] = '{210828714, 124459457, 65760959, 33381290, 16755422,
      8385879, 4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768,
      16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

   logic [31:0] start_q, step_q, low_q, high_q, scale_q;
   logic [63:0] row0_q, row1_q, offset_q;
   point_type   expected_points [$];

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint apply_row(logic [63:0] row, longint px, longint py,
                                        logic [31:0] t);
      longint acc;
      acc = longint'($signed(row[31:0])) * px + longint'($signed(row[63:32])) * py
            + (64'sd1 <<< 29);
      return clamp((acc >>> 30) + longint'($signed(t)), -64'sd2147483648,
                   64'sd2147483647);
   endfunction

   function automatic point_type predict_point(logic [31:0] range, logic [10:0] beam,
                                               logic last);
      point_type p;
      longint ang, z, x, y, dx, dy, px, py;
      logic [63:0] s;
      logic flip;
      ang = longint'($signed(start_q)) + longint'($signed(step_q)) * longint'(beam);
      p = '0;
      p.angle = ang[31:0];
      p.last = last;
      p.kept = !(range <= low_q || range >= high_q || range == '1 || range == 0 ||
                 beam >= lstp_pkg::MAX_BEAMS);
      if (p.kept) begin
         s = ({32'd0, range} * {32'd0, scale_q}) >> 30;
         if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
         z = longint'($signed(ang[31:0]));
         flip = 1'b0;
         if (z > PI_Q28) z -= TWO_PI_Q28;
         else if (z < -PI_Q28) z += TWO_PI_Q28;
         if (z > HALF_PI_Q28) begin
            z -= PI_Q28;
            flip = 1'b1;
         end else if (z < -HALF_PI_Q28) begin
            z += PI_Q28;
            flip = 1'b1;
         end
         x = longint'((s * GAIN_Q30) >> 22);
         y = 0;
         for (int i = 0; i < 28; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= atan_q28[i];
            end else begin
               x += dx; y -= dy; z += atan_q28[i];
            end
         end
         if (flip) begin
            x = -x; y = -y;
         end
         px = clamp((x + 128) >>> 8, -64'sd2147483647, 64'sd2147483647);
         py = clamp((y + 128) >>> 8, -64'sd2147483647, 64'sd2147483647);
         p.x = 32'(apply_row(row0_q, px, py, offset_q[31:0]));
         p.y = 32'(apply_row(row1_q, px, py, offset_q[63:32]));
      end
      return p;
   endfunction

   always @(posedge clock) begin
      point_type e, a;
      if (reset) begin
         start_q <= '0; step_q <= '0; low_q <= '0; high_q <= '1;
         scale_q <= 32'h4000_0000;
         row0_q <= 64'h0000_0000_4000_0000;
         row1_q <= 64'h4000_0000_0000_0000;
         offset_q <= '0;
         error_count <= 0;
         pending_points <= 0;
         expected_points.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lstp_pkg::REG_ANGLE_START: start_q <= csr_data[31:0];
               lstp_pkg::REG_ANGLE_STEP:  step_q <= csr_data[31:0];
               lstp_pkg::REG_RANGE_LOW:   low_q <= csr_data[31:0];
               lstp_pkg::REG_RANGE_HIGH:  high_q <= csr_data[31:0];
               lstp_pkg::REG_RANGE_SCALE: scale_q <= csr_data[31:0];
               lstp_pkg::REG_ROT_ROW0:    row0_q <= csr_data;
               lstp_pkg::REG_ROT_ROW1:    row1_q <= csr_data;
               lstp_pkg::REG_TRANSLATION: offset_q <= csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_points = {expected_points,
                               predict_point(req_tdata[31:0], req_tdata[42:32], req_tlast)};
         if (rsp_tvalid && rsp_tready) begin
            a = {rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                 rsp_tlast};
            if (expected_points.size() == 0) begin
               $display("%0t: unexpected result %h", $time, a);
               error_count <= error_count + 1;
            end else begin
               e = expected_points.pop_front();
               if (e != a) begin
                  $display("%0t: mismatch kept %b/%b x %h/%h y %h/%h angle %h/%h last %b/%b",
                           $time, e.kept, a.kept, e.x, a.x, e.y, a.y, e.angle, a.angle,
                           e.last, a.last);
                  error_count <= error_count + 1;
               end
            end
         end
         pending_points <= expected_points.size();
      end
   end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lidar scan to points: testbench top
// Drives directed and random samples through several register settings and
// stall patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

   logic        clock = 0, reset = 1;
   logic        req_tvalid = 0, req_tlast = 0, rsp_tready = 0;
   logic [47:0] req_tdata = '0;
   logic        csr_valid = 0;
   logic [3:0]  csr_index = '0;
   logic [63:0] csr_data = '0;
   logic        req_tready, rsp_tvalid, rsp_tuser, rsp_tlast, csr_ready;
   logic [95:0] rsp_tdata;
   int          error_count, pending_points;
   int          send_idle_pct = 0, recv_stall_pct = 0, hold_off = 0;
   longint      cycle_count = 0;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   lidar_scan_to_points_core dut (.*);

   lstp_scoreboard scoreboard_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("** lidar_scan_to_points_core: FAILED **");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off when requested
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic write_reg(lstp_pkg::csr_index_type idx, logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_sample(logic [31:0] range, logic [10:0] beam, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, beam, range};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_points != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_range();
      case ($urandom_range(5))
         0: return $urandom_range(255);
         1: return 32'hFFFF_FFFF - $urandom_range(3);
         default: return $urandom_range(32'h0080_0000);
      endcase
   endfunction

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++)
         send_sample($urandom_range(9) == 0 ? $urandom() : rand_range(),
                     $urandom_range(9) == 0 ? 11'($urandom()) : 11'($urandom_range(1439)),
                     $urandom_range(15) == 0);
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed samples at reset settings
      send_sample(32'd0, 11'd0, 1'b0);
      send_sample(32'hFFFF_FFFF, 11'd1, 1'b0);
      send_sample(32'hFFFF_FFFE, 11'd2, 1'b0);
      send_sample(32'd1, 11'd1439, 1'b1);
      send_sample(32'h0001_0000, 11'd1440, 1'b0);
      send_sample(32'h0001_0000, 11'h7FF, 1'b1);
      drain();
      write_reg(lstp_pkg::REG_ANGLE_START, 64'hFFFF_FFFF_CDBC_46A5); // about -pi
      write_reg(lstp_pkg::REG_ANGLE_STEP, 64'd1171746);             // about 2*pi / 1440
      write_reg(lstp_pkg::REG_RANGE_LOW, 64'h0000_8000);
      write_reg(lstp_pkg::REG_RANGE_HIGH, 64'h0064_0000);
      write_reg(lstp_pkg::REG_RANGE_SCALE, 64'hFFFF_FFFF);
      write_reg(lstp_pkg::REG_ROT_ROW0, 64'hC000_0000_4000_0000);
      write_reg(lstp_pkg::REG_ROT_ROW1, 64'h4000_0000_4000_0000);
      write_reg(lstp_pkg::REG_TRANSLATION, 64'h8000_0000_7FFF_FFFF);
      send_sample(32'h0000_8000, 11'd0, 1'b0);
      send_sample(32'h0000_8001, 11'd360, 1'b0);
      send_sample(32'h0064_0000, 11'd720, 1'b0);
      send_sample(32'h0063_FFFF, 11'd1080, 1'b0);
      send_sample(32'h0010_0000, 11'd1439, 1'b1);
      drain();
      write_reg(lstp_pkg::REG_ANGLE_START, 64'h7FFF_FFFF);
      write_reg(lstp_pkg::REG_ANGLE_STEP, 64'h8000_0000);
      write_reg(lstp_pkg::REG_RANGE_LOW, 64'd0);
      write_reg(lstp_pkg::REG_RANGE_HIGH, 64'hFFFF_FFFF);
      write_reg(lstp_pkg::REG_ROT_ROW0, 64'h7FFF_FFFF_7FFF_FFFF);
      write_reg(lstp_pkg::REG_ROT_ROW1, 64'h8000_0000_8000_0000);
      write_reg(lstp_pkg::REG_TRANSLATION, 64'd0);
      for (int i = 0; i < 6; i++)
         send_sample(32'hFFFF_FFFE - i, 11'(i * 287), i[0]);
      drain();
      // random phases over stall patterns and settings
      for (int ph = 0; ph < 5; ph++) begin
         send_idle_pct = (ph == 1 || ph == 4) ? 80 : (ph == 3 ? 8 : 0);
         recv_stall_pct = (ph == 2 || ph == 4) ? 80 : (ph == 3 ? 8 : 0);
         write_reg(lstp_pkg::REG_ANGLE_START, {32'd0, $urandom()});
         write_reg(lstp_pkg::REG_ANGLE_STEP,
                   {32'd0, ph == 0 ? $urandom() : $urandom_range(2000000)});
         write_reg(lstp_pkg::REG_RANGE_LOW, {32'd0, 32'($urandom_range(4096))});
         write_reg(lstp_pkg::REG_RANGE_HIGH,
                   {32'd0, ph[0] ? 32'hFFFF_FFFF : 32'($urandom())});
         write_reg(lstp_pkg::REG_RANGE_SCALE,
                   {32'd0, ph == 3 ? 32'h4000_0000 : $urandom()});
         write_reg(lstp_pkg::REG_ROT_ROW0, {$urandom(), $urandom()});
         write_reg(lstp_pkg::REG_ROT_ROW1, {$urandom(), $urandom()});
         write_reg(lstp_pkg::REG_TRANSLATION, {$urandom(), $urandom()});
         write_reg(lstp_pkg::csr_index_type'(4'd9), 64'hFFFF_FFFF_FFFF_FFFF);
         if (ph == 0) hold_off = 200;
         random_phase(ph == 0 ? 150 : 110);
      end
      if (error_count == 0)
         $display("** lidar_scan_to_points_core: PASSED **");
      else
         $display("** lidar_scan_to_points_core: FAILED **");
      $finish;
   end

endmodule
